FILE: src/spq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types, sizes and address helpers for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int CAPACITY      = 64;
    localparam int ADDR_W        = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W         = $clog2(CAPACITY + 1);
    localparam int ENTRY_COUNT_W = 7;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } t_op;

    typedef struct packed {
        t_op         operation;
        logic [15:0] priority_req;
        logic [31:0] name_tag;
        logic [31:0] surname_tag;
    } t_in;

    typedef struct packed {
        logic                     front_valid;
        logic [15:0]              front_priority;
        logic [31:0]              front_name;
        logic [31:0]              front_surname;
        logic [ENTRY_COUNT_W-1:0] entry_count;
        logic                     rejected;
    } t_out;

    typedef struct packed {
        logic [15:0] prio;
        logic [31:0] name;
        logic [31:0] surname;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_PUT,
        S_POP_LD
    } t_state;

    // Physical slot of a logical position, ring buffer starting at head.
    function automatic logic [ADDR_W-1:0] f_phys(input logic [ADDR_W-1:0] head,
                                                 input logic [ADDR_W-1:0] idx);
        logic [ADDR_W:0] sum;
        sum = {1'b0, head} + {1'b0, idx};
        if (sum >= (ADDR_W+1)'(CAPACITY)) begin
            sum = sum - (ADDR_W+1)'(CAPACITY);
        end
        return sum[ADDR_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] f_inc(input logic [ADDR_W-1:0] a);
        logic [ADDR_W-1:0] r;
        if (a == ADDR_W'(CAPACITY - 1)) begin
            r = '0;
        end else begin
            r = a + 1'b1;
        end
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] f_dec(input logic [ADDR_W-1:0] a);
        logic [ADDR_W-1:0] r;
        if (a == '0) begin
            r = ADDR_W'(CAPACITY - 1);
        end else begin
            r = a - 1'b1;
        end
        return r;
    endfunction

endpackage

FILE: src/sorted_priority_queue_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit
// Max-first priority queue of CAPACITY entries held in sorted order in one
// synchronous RAM used as a ring buffer.
// ----------------------------------------------------------------------------
// Each input beat is one insert or remove and gives exactly one result beat.
// Entries live in a single-port-write, single-port-read RAM addressed as a
// ring; the front entry is mirrored in registers. A remove, an insert that
// becomes the new front, an insert on a full queue and a remove on an empty
// queue need no walk. Any other insert walks the RAM from the tail
// toward the front, one entry per cycle, moving each entry of lower or equal
// priority back by one slot until it meets a higher one or reaches the slot
// behind the front, where the new entry is written. A finished result sits
// in an output register, so the queue keeps taking beats while the result
// waits; it stalls only when a second result is ready to leave.
// No clearing pass after reset.
module sorted_priority_queue_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  spq_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output spq_pkg::t_out o_data
);
    import spq_pkg::*;

    t_entry r_mem [CAPACITY];
    t_entry r_rd_data;

    t_state            r_state, n_state;
    t_in               r_req,   n_req;
    logic [ADDR_W-1:0] r_head,  n_head;
    logic [CNT_W-1:0]  r_count, n_count;
    t_entry            r_front, n_front;
    logic [ADDR_W-1:0] r_j,     n_j;
    logic [ADDR_W-1:0] r_pos,   n_pos;
    t_out              r_out,   n_out;
    logic              r_out_valid;
    logic              out_load;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    t_entry            mem_wd;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_ra;

    logic              out_free;
    t_entry            new_entry;
    logic [CNT_W-1:0]  cnt_inc;
    logic [CNT_W-1:0]  cnt_dec;
    logic [ADDR_W-1:0] head_inc;

    assign o_ready   = (r_state == S_IDLE);
    assign o_valid   = r_out_valid;
    assign o_data    = r_out;
    assign out_free  = !r_out_valid || i_ready;
    assign new_entry = '{prio: r_req.priority_req, name: r_req.name_tag,
                         surname: r_req.surname_tag};
    assign cnt_inc   = r_count + 1'b1;
    assign cnt_dec   = r_count - 1'b1;
    assign head_inc  = f_inc(r_head);

    // entry RAM
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req   <= n_req;
        r_front <= n_front;
        r_j     <= n_j;
        r_pos   <= n_pos;
        if (out_load) begin
            r_out <= n_out;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_req    = r_req;
        n_head   = r_head;
        n_count  = r_count;
        n_front  = r_front;
        n_j      = r_j;
        n_pos    = r_pos;
        n_out    = '0;
        out_load = 1'b0;
        mem_we   = 1'b0;
        mem_wa   = '0;
        mem_wd   = new_entry;
        mem_re   = 1'b0;
        mem_ra   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_req   = i_data;
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                if (r_req.operation == OP_INSERT) begin
                    priority if (r_count == CNT_W'(CAPACITY)) begin
                        if (out_free) begin
                            out_load            = 1'b1;
                            n_out.front_valid    = 1'b1;
                            n_out.front_priority = r_front.prio;
                            n_out.front_name     = r_front.name;
                            n_out.front_surname  = r_front.surname;
                            n_out.entry_count    = ENTRY_COUNT_W'(r_count);
                            n_out.rejected       = 1'b1;
                            n_state              = S_IDLE;
                        end
                    end else if (r_count == '0 ||
                                 r_req.priority_req > r_front.prio) begin
                        // new front: grow the ring backward, nothing moves
                        if (out_free) begin
                            mem_we               = 1'b1;
                            mem_wa               = f_dec(r_head);
                            n_head               = f_dec(r_head);
                            n_front              = new_entry;
                            n_count              = cnt_inc;
                            out_load             = 1'b1;
                            n_out.front_valid    = 1'b1;
                            n_out.front_priority = new_entry.prio;
                            n_out.front_name     = new_entry.name;
                            n_out.front_surname  = new_entry.surname;
                            n_out.entry_count    = ENTRY_COUNT_W'(cnt_inc);
                            n_state              = S_IDLE;
                        end
                    end else if (r_count == CNT_W'(1)) begin
                        n_pos   = ADDR_W'(1);
                        n_state = S_PUT;
                    end else begin
                        mem_re  = 1'b1;
                        mem_ra  = f_phys(r_head, ADDR_W'(cnt_dec));
                        n_j     = ADDR_W'(cnt_dec);
                        n_state = S_SCAN;
                    end
                end else begin
                    if (out_free) begin
                        out_load = 1'b1;
                        n_state  = S_IDLE;
                        if (r_count != '0) begin
                            n_out.front_valid    = 1'b1;
                            n_out.front_priority = r_front.prio;
                            n_out.front_name     = r_front.name;
                            n_out.front_surname  = r_front.surname;
                            n_out.entry_count    = ENTRY_COUNT_W'(cnt_dec);
                            n_head               = head_inc;
                            n_count              = cnt_dec;
                            if (cnt_dec != '0) begin
                                // fetch the next front
                                mem_re  = 1'b1;
                                mem_ra  = head_inc;
                                n_state = S_POP_LD;
                            end
                        end
                    end
                end
            end

            S_SCAN: begin
                // r_rd_data holds logical entry r_j
                if (r_rd_data.prio <= r_req.priority_req) begin
                    mem_we = 1'b1;
                    mem_wa = f_phys(r_head, r_j + 1'b1);
                    mem_wd = r_rd_data;
                    if (r_j == ADDR_W'(1)) begin
                        n_pos   = ADDR_W'(1);
                        n_state = S_PUT;
                    end else begin
                        mem_re = 1'b1;
                        mem_ra = f_phys(r_head, r_j - 1'b1);
                        n_j    = r_j - 1'b1;
                    end
                end else begin
                    n_pos   = r_j + 1'b1;
                    n_state = S_PUT;
                end
            end

            S_PUT: begin
                if (out_free) begin
                    mem_we               = 1'b1;
                    mem_wa               = f_phys(r_head, r_pos);
                    n_count              = cnt_inc;
                    out_load             = 1'b1;
                    n_out.front_valid    = 1'b1;
                    n_out.front_priority = r_front.prio;
                    n_out.front_name     = r_front.name;
                    n_out.front_surname  = r_front.surname;
                    n_out.entry_count    = ENTRY_COUNT_W'(cnt_inc);
                    n_state              = S_IDLE;
                end
            end

            S_POP_LD: begin
                n_front = r_rd_data;
                n_state = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: src/spq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks for the sorted priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module spq_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input logic          o_ready,
    input spq_pkg::t_in  i_data,
    input logic          o_valid,
    input logic          i_ready,
    input spq_pkg::t_out o_data
);
    import spq_pkg::*;

    // a request beat that is not taken holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_data))
        else $error("request beat changed while stalled");

    // a result beat that is not taken holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result beat changed while stalled");

    // no reported entry means an empty queue and zeroed fields
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.front_valid |->
            o_data.entry_count == '0 && o_data.front_priority == '0 &&
            o_data.front_name == '0 && o_data.front_surname == '0 &&
            !o_data.rejected)
        else $error("empty result carries data");

    // a refused insert only happens on a full queue
    a_reject_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.rejected |->
            o_data.entry_count == ENTRY_COUNT_W'(CAPACITY) && o_data.front_valid)
        else $error("reject without a full queue");

    // ready drops right after the queue takes a beat
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready right after accept");

endmodule

bind sorted_priority_queue_unit spq_checker u_spq_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .i_data  (i_data),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);

FILE: tb/sorted_priority_queue_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit_checker
// Watches both channels of the priority queue. Each accepted request beat
// runs through a behavioral copy of the sorted queue to build the expected
// result beat, and each accepted result beat is checked field by field
// against the oldest expected one.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_ready,
    input  spq_pkg::t_in  i_in_beat,
    input  logic          i_out_valid,
    input  logic          i_out_ready,
    input  spq_pkg::t_out i_out_beat,
    output int            o_fail_count,
    output int            o_pending
);
    import spq_pkg::*;

    localparam int REPORT_LIMIT = 10;

    t_entry sorted_entries[$];   // slot 0 is the front
    t_out   expected_fronts[$];
    t_out   want;
    int     result_idx;

    // Applies one request to the shadow queue and returns the result it gives.
    function automatic t_out predict_queue_op(input t_in req);
        t_out   res;
        t_entry ent;
        int     pos;
        res = '0;
        if (req.operation == OP_INSERT) begin
            if (sorted_entries.size() >= CAPACITY) begin
                res.rejected = 1'b1;
            end else begin
                ent.prio    = req.priority_req;
                ent.name    = req.name_tag;
                ent.surname = req.surname_tag;
                if (sorted_entries.size() == 0 || req.priority_req > sorted_entries[0].prio) begin
                    pos = 0;
                end else begin
                    // equal to the front still lands right behind it
                    pos = 1;
                    while (pos < sorted_entries.size() &&
                           sorted_entries[pos].prio > req.priority_req) begin
                        pos++;
                    end
                end
                sorted_entries.insert(pos, ent);
            end
            if (sorted_entries.size() != 0) begin
                res.front_valid    = 1'b1;
                res.front_priority = sorted_entries[0].prio;
                res.front_name     = sorted_entries[0].name;
                res.front_surname  = sorted_entries[0].surname;
            end
        end else if (sorted_entries.size() != 0) begin
            ent                = sorted_entries.pop_front();
            res.front_valid    = 1'b1;
            res.front_priority = ent.prio;
            res.front_name     = ent.name;
            res.front_surname  = ent.surname;
        end
        res.entry_count = ENTRY_COUNT_W'(sorted_entries.size());
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sorted_entries.delete();
            expected_fronts.delete();
        end else begin
            // a result can never leave on the edge its request enters,
            // so checking before predicting is safe
            if (i_out_valid && i_out_ready) begin
                if (expected_fronts.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= REPORT_LIMIT) begin
                        $display("%0t: result beat %0d with nothing expected: %h",
                                 $realtime, result_idx, i_out_beat);
                    end
                end else begin
                    want = expected_fronts.pop_front();
                    if (i_out_beat.front_valid    !== want.front_valid    ||
                        i_out_beat.front_priority !== want.front_priority ||
                        i_out_beat.front_name     !== want.front_name     ||
                        i_out_beat.front_surname  !== want.front_surname  ||
                        i_out_beat.entry_count    !== want.entry_count    ||
                        i_out_beat.rejected       !== want.rejected) begin
                        o_fail_count++;
                        if (o_fail_count <= REPORT_LIMIT) begin
                            $display("%0t: result beat %0d mismatch", $realtime, result_idx);
                            $display("  expected v=%b p=%h n=%h s=%h cnt=%0d rej=%b",
                                     want.front_valid, want.front_priority,
                                     want.front_name, want.front_surname,
                                     want.entry_count, want.rejected);
                            $display("  actual   v=%b p=%h n=%h s=%h cnt=%0d rej=%b",
                                     i_out_beat.front_valid, i_out_beat.front_priority,
                                     i_out_beat.front_name, i_out_beat.front_surname,
                                     i_out_beat.entry_count, i_out_beat.rejected);
                        end
                    end
                end
                result_idx++;
            end
            if (i_in_valid && i_in_ready) begin
                expected_fronts.push_back(predict_queue_op(i_in_beat));
            end
        end
        o_pending = expected_fronts.size();
    end

endmodule

FILE: tb/sorted_priority_queue_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit_tb
// Drives inserts and removes into the priority queue with random gaps and
// result back-pressure; a checker beside the block predicts and compares
// every result beat.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit_tb;
    import spq_pkg::*;

    localparam int  RANDOM_BEATS = 1230;
    localparam int  SETTLE_CYCLES = CAPACITY + 16;
    localparam time TIMEOUT_NS = 2_000_000;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    t_in  i_data;
    logic o_valid;
    logic i_ready;
    t_out o_data;

    int          fail_count;
    int          pending_count;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          held_count;    // rough occupancy, only used to steer stimulus
    logic        filling;
    logic [15:0] last_prio;

    sorted_priority_queue_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    sorted_priority_queue_unit_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_in_beat    (i_data),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_out_beat   (o_data),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("sorted_priority_queue_unit_tb NOT OK");
        $finish;
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic t_in make_req(input t_op op, input logic [15:0] prio,
                                     input logic [31:0] name, input logic [31:0] surname);
        t_in req;
        req.operation    = op;
        req.priority_req = prio;
        req.name_tag     = name;
        req.surname_tag  = surname;
        return req;
    endfunction

    // Clustered priorities so ties with the front and with the tail are common.
    function automatic logic [15:0] pick_priority();
        logic [15:0] prio;
        case ($urandom_range(3))
            0: prio = 16'($urandom);
            1: prio = 16'($urandom_range(7));
            2: prio = 16'hFFF8 + 16'($urandom_range(7));
            default: prio = last_prio;
        endcase
        return prio;
    endfunction

    // Alternates fill and drain runs so the queue hits both full and empty.
    function automatic t_in random_req();
        t_op op;
        if (held_count == CAPACITY && $urandom_range(3) == 0) begin
            filling = 1'b0;
        end
        if (held_count == 0 && $urandom_range(3) == 0) begin
            filling = 1'b1;
        end
        if (filling) begin
            op = ($urandom_range(99) < 80) ? OP_INSERT : OP_REMOVE;
        end else begin
            op = ($urandom_range(99) < 80) ? OP_REMOVE : OP_INSERT;
        end
        last_prio = pick_priority();
        return make_req(op, last_prio, $urandom, $urandom);
    endfunction

    task automatic send_beat(input t_in req);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= req;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        if (req.operation == OP_INSERT && held_count < CAPACITY) begin
            held_count++;
        end else if (req.operation == OP_REMOVE && held_count > 0) begin
            held_count--;
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_data        = '0;
        i_ready       = 1'b0;
        send_idle_pct = 35;
        recv_idle_pct = 71;
        held_count    = 0;
        filling       = 1'b1;
        last_prio     = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty pop, new front, ties with front, tail, extremes
        send_beat(make_req(OP_REMOVE, 16'h1234, 32'h1111_1111, 32'h2222_2222));
        send_beat(make_req(OP_INSERT, 16'h8000, 32'hA000_0001, 32'hB000_0001));
        send_beat(make_req(OP_INSERT, 16'h8000, 32'hA000_0002, 32'hB000_0002));
        send_beat(make_req(OP_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_beat(make_req(OP_INSERT, 16'h0000, 32'h0000_0000, 32'h0000_0000));
        send_beat(make_req(OP_INSERT, 16'h8000, 32'hA000_0003, 32'hB000_0003));
        send_beat(make_req(OP_INSERT, 16'hFFFF, 32'h5555_5555, 32'hAAAA_AAAA));
        send_beat(make_req(OP_INSERT, 16'h7FFF, 32'hAAAA_AAAA, 32'h5555_5555));
        send_beat(make_req(OP_INSERT, 16'h0000, 32'hC000_0001, 32'hD000_0001));
        send_beat(make_req(OP_INSERT, 16'h8001, 32'hC000_0002, 32'hD000_0002));
        repeat (10) begin
            send_beat(make_req(OP_REMOVE, 16'($urandom), $urandom, $urandom));
        end

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 35;
                    recv_idle_pct = 71;
                end
                1: begin
                    send_idle_pct = 71;
                    recv_idle_pct = 35;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            repeat (RANDOM_BEATS / 3) begin
                send_beat(random_req());
            end
        end
        i_valid <= 1'b0;

        @(posedge i_clk);
        wait (pending_count == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("sorted_priority_queue_unit_tb OK");
        end else begin
            $display("sorted_priority_queue_unit_tb NOT OK");
        end
        $finish;
    end

endmodule

FILE: sorted_priority_queue_unit.f
src/spq_pkg.sv
src/sorted_priority_queue_unit.sv
src/spq_checker.sv
tb/sorted_priority_queue_unit_checker.sv
tb/sorted_priority_queue_unit_tb.sv
